### rtl/dec_pkg.sv
// shared widths, request record and helpers for the disk collision unit
`timescale 1ns / 1ps
`default_nettype none
package dec_pkg;

  localparam int POS_BITS  = 16;
  localparam int VEL_BITS  = 16;
  localparam int MASS_BITS = 8;
  localparam int RAD_BITS  = 12;

  localparam int DIFF_W = POS_BITS + 1;
  localparam int RSUM_W = RAD_BITS + 1;
  localparam int SQ_W   = 2 * DIFF_W;
  localparam int NN_W   = 2 * RSUM_W + 1;
  localparam int DX_W   = RSUM_W + 1;
  localparam int DD_W   = 32;
  localparam int MSUM_W = MASS_BITS + 1;

  localparam int DIV_N = 46;
  localparam int DIV_D = 27;
  localparam int DIV_Q = 32;

  localparam int DELTA_W = 22;
  localparam int SUM_W   = 23;
  localparam int QDEPTH  = 2;

  typedef struct packed {
    logic                       hit;
    logic                       bypass;
    logic signed [DD_W-1:0]     dd;
    logic [NN_W-1:0]            nn;
    logic signed [DX_W-1:0]     dx;
    logic signed [DX_W-1:0]     dy;
    logic [MASS_BITS-1:0]       m1;
    logic [MASS_BITS-1:0]       m2;
    logic [MSUM_W-1:0]          msum;
    logic signed [VEL_BITS-1:0] v1x;
    logic signed [VEL_BITS-1:0] v1y;
    logic signed [VEL_BITS-1:0] v2x;
    logic signed [VEL_BITS-1:0] v2y;
  } dec_item_t;

  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'((1 << (VEL_BITS - 1)) - 1);
  localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_MAX - SUM_W'(1);

  function automatic logic signed [VEL_BITS-1:0] sat_vel(input logic signed [SUM_W-1:0] x);
    logic signed [VEL_BITS-1:0] r;
    if (x > SUM_MAX) begin
      r = SUM_MAX[VEL_BITS-1:0];
    end else if (x < SUM_MIN) begin
      r = SUM_MIN[VEL_BITS-1:0];
    end else begin
      r = x[VEL_BITS-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/dec_div.sv
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none
module dec_div (
  input  wire logic                      clk_i,
  input  wire logic [dec_pkg::DIV_N-1:0] num_i,
  input  wire logic [dec_pkg::DIV_D-1:0] den_i,
  output logic      [dec_pkg::DIV_Q-1:0] quo_o
);

  logic [dec_pkg::DIV_N-1:0] rem_q [dec_pkg::DIV_Q];
  logic [dec_pkg::DIV_D-1:0] den_q [dec_pkg::DIV_Q];
  logic [dec_pkg::DIV_Q-1:0] quo_q [dec_pkg::DIV_Q];

  for (genvar k = 0; k < dec_pkg::DIV_Q; k++) begin : g_stage
    logic [dec_pkg::DIV_N-1:0] rin;
    logic [dec_pkg::DIV_D-1:0] din;
    logic [dec_pkg::DIV_Q-1:0] qin;
    logic                      ge;
    if (k == 0) begin : g_first
      assign rin = num_i;
      assign din = den_i;
      assign qin = '0;
    end else begin : g_next
      assign rin = rem_q[k-1];
      assign din = den_q[k-1];
      assign qin = quo_q[k-1];
    end
    assign ge = (rin >> (dec_pkg::DIV_Q - 1 - k)) >= dec_pkg::DIV_N'(din);
    always_ff @(posedge clk_i) begin
      rem_q[k] <= ge ? rin - (dec_pkg::DIV_N'(din) << (dec_pkg::DIV_Q - 1 - k)) : rin;
      den_q[k] <= din;
      quo_q[k] <= {qin[dec_pkg::DIV_Q-2:0], ge};
    end
  end

  assign quo_o = quo_q[dec_pkg::DIV_Q-1];

endmodule
`default_nettype wire

### rtl/dec_front.sv
// front end: offsets, contact test and classification of each request
`timescale 1ns / 1ps
`default_nettype none
module dec_front (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                accept_i,
  input  wire logic signed [dec_pkg::POS_BITS-1:0] first_pos_x_i,
  input  wire logic signed [dec_pkg::POS_BITS-1:0] first_pos_y_i,
  input  wire logic signed [dec_pkg::POS_BITS-1:0] second_pos_x_i,
  input  wire logic signed [dec_pkg::POS_BITS-1:0] second_pos_y_i,
  input  wire logic signed [dec_pkg::VEL_BITS-1:0] first_vel_x_i,
  input  wire logic signed [dec_pkg::VEL_BITS-1:0] first_vel_y_i,
  input  wire logic signed [dec_pkg::VEL_BITS-1:0] second_vel_x_i,
  input  wire logic signed [dec_pkg::VEL_BITS-1:0] second_vel_y_i,
  input  wire logic [dec_pkg::MASS_BITS-1:0]       first_mass_i,
  input  wire logic [dec_pkg::MASS_BITS-1:0]       second_mass_i,
  input  wire logic [dec_pkg::RAD_BITS-1:0]        first_radius_i,
  input  wire logic [dec_pkg::RAD_BITS-1:0]        second_radius_i,
  output logic                                     push_o,
  output dec_pkg::dec_item_t                       item_o
);

  localparam int AW = dec_pkg::DIFF_W + 1;

  logic                                v1_q, v2_q;
  logic signed [dec_pkg::DIFF_W-1:0]   dx1_q, dy1_q, dvx1_q, dvy1_q;
  logic [dec_pkg::RSUM_W-1:0]          rsum1_q;
  logic [dec_pkg::MASS_BITS-1:0]       m1_1_q, m2_1_q, m1_2_q, m2_2_q;
  logic signed [dec_pkg::VEL_BITS-1:0] va1_q [4];
  logic signed [dec_pkg::VEL_BITS-1:0] va2_q [4];

  logic [AW-1:0]                       ax, ay;
  logic                                far2_q;
  logic signed [dec_pkg::SQ_W-1:0]     sqx2_q, sqy2_q, px2_q, py2_q;
  logic [2*dec_pkg::RSUM_W-1:0]        rr2_q;
  logic signed [dec_pkg::DX_W-1:0]     dx2_q, dy2_q;
  logic [dec_pkg::MSUM_W-1:0]          msum2_q;

  logic signed [dec_pkg::SQ_W:0]       nn;
  logic signed [dec_pkg::SQ_W:0]       dot;
  logic                                hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= accept_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dx1_q   <= dec_pkg::DIFF_W'(second_pos_x_i) - dec_pkg::DIFF_W'(first_pos_x_i);
    dy1_q   <= dec_pkg::DIFF_W'(second_pos_y_i) - dec_pkg::DIFF_W'(first_pos_y_i);
    dvx1_q  <= dec_pkg::DIFF_W'(second_vel_x_i) - dec_pkg::DIFF_W'(first_vel_x_i);
    dvy1_q  <= dec_pkg::DIFF_W'(second_vel_y_i) - dec_pkg::DIFF_W'(first_vel_y_i);
    rsum1_q <= dec_pkg::RSUM_W'(first_radius_i) + dec_pkg::RSUM_W'(second_radius_i);
    m1_1_q  <= first_mass_i;
    m2_1_q  <= second_mass_i;
    va1_q[0] <= first_vel_x_i;
    va1_q[1] <= first_vel_y_i;
    va1_q[2] <= second_vel_x_i;
    va1_q[3] <= second_vel_y_i;
  end

  assign ax = dx1_q[dec_pkg::DIFF_W-1] ? -AW'(dx1_q) : AW'(dx1_q);
  assign ay = dy1_q[dec_pkg::DIFF_W-1] ? -AW'(dy1_q) : AW'(dy1_q);

  always_ff @(posedge clk_i) begin
    far2_q  <= (ax > AW'(rsum1_q)) || (ay > AW'(rsum1_q));
    sqx2_q  <= dx1_q * dx1_q;
    sqy2_q  <= dy1_q * dy1_q;
    px2_q   <= dvx1_q * dx1_q;
    py2_q   <= dvy1_q * dy1_q;
    rr2_q   <= rsum1_q * rsum1_q;
    dx2_q   <= dx1_q[dec_pkg::DX_W-1:0];
    dy2_q   <= dy1_q[dec_pkg::DX_W-1:0];
    msum2_q <= dec_pkg::MSUM_W'(m1_1_q) + dec_pkg::MSUM_W'(m2_1_q);
    m1_2_q  <= m1_1_q;
    m2_2_q  <= m2_1_q;
    va2_q   <= va1_q;
  end

  assign nn  = (dec_pkg::SQ_W + 1)'(sqx2_q) + (dec_pkg::SQ_W + 1)'(sqy2_q);
  assign dot = (dec_pkg::SQ_W + 1)'(px2_q) + (dec_pkg::SQ_W + 1)'(py2_q);
  assign hit = !far2_q && ($unsigned(nn) <= (dec_pkg::SQ_W + 1)'(rr2_q));

  always_comb begin
    item_o.hit    = hit;
    item_o.bypass = !hit || (nn == '0) || (msum2_q == '0);
    item_o.dd     = dot[dec_pkg::DD_W-1:0];
    item_o.nn     = nn[dec_pkg::NN_W-1:0];
    item_o.dx     = dx2_q;
    item_o.dy     = dy2_q;
    item_o.m1     = m1_2_q;
    item_o.m2     = m2_2_q;
    item_o.msum   = msum2_q;
    item_o.v1x    = va2_q[0];
    item_o.v1y    = va2_q[1];
    item_o.v2x    = va2_q[2];
    item_o.v2y    = va2_q[3];
  end

  assign push_o = v2_q;

endmodule
`default_nettype wire

### rtl/dec_queue.sv
// short request queue between front and back end
`timescale 1ns / 1ps
`default_nettype none
module dec_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire dec_pkg::dec_item_t item_i,
  output logic                    full_o,
  output logic                    valid_o,
  output dec_pkg::dec_item_t      item_o
);

  dec_pkg::dec_item_t mem_q [dec_pkg::QDEPTH];
  logic               wr_ptr_q, rd_ptr_q;
  logic [1:0]         cnt_q;
  logic               pop;

  assign pop     = cnt_q != 2'd0;
  assign valid_o = pop;
  assign item_o  = mem_q[rd_ptr_q];
  assign full_o  = cnt_q == 2'(dec_pkg::QDEPTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("request pushed into full queue");
  a_cnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(dec_pkg::QDEPTH))
    else $error("queue fill count out of range");
`endif

endmodule
`default_nettype wire

### rtl/dec_back.sv
// back end: impulse along the centre line, rounding divisions and saturation
`timescale 1ns / 1ps
`default_nettype none
module dec_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          valid_i,
  input  wire dec_pkg::dec_item_t            item_i,
  output logic                               done_o,
  output logic                               contact_o,
  output logic signed [dec_pkg::VEL_BITS-1:0] new_first_vel_x_o,
  output logic signed [dec_pkg::VEL_BITS-1:0] new_first_vel_y_o,
  output logic signed [dec_pkg::VEL_BITS-1:0] new_second_vel_x_o,
  output logic signed [dec_pkg::VEL_BITS-1:0] new_second_vel_y_o
);

  localparam int QS_W = dec_pkg::DIV_Q + 1;
  localparam int P_W  = QS_W + dec_pkg::DX_W;
  localparam int MP_W = dec_pkg::DD_W + dec_pkg::MASS_BITS;

  typedef struct packed {
    logic                       hit;
    logic                       bypass;
    logic                       s1;
    logic                       s2;
    logic [dec_pkg::NN_W-1:0]   nn;
    logic signed [dec_pkg::DX_W-1:0] dx;
    logic signed [dec_pkg::DX_W-1:0] dy;
    logic [4*dec_pkg::VEL_BITS-1:0]  v;
  } dec_side_t;

  typedef struct packed {
    logic                           hit;
    logic                           bypass;
    logic [3:0]                     sg;
    logic [4*dec_pkg::VEL_BITS-1:0] v;
  } dec_tail_t;

  // stage b0: impulse numerators
  logic [dec_pkg::DD_W-1:0]  absdd;
  logic [MP_W-1:0]           mp1, mp2;
  logic                      b0_valid_q;
  logic [dec_pkg::DIV_N-1:0] num1_q, num2_q;
  logic [dec_pkg::DIV_D-1:0] den1_q;
  dec_side_t                 side0_q;
  logic [dec_pkg::DIV_Q-1:0] quo1, quo2;

  assign absdd = item_i.dd[dec_pkg::DD_W-1] ? -item_i.dd : item_i.dd;
  assign mp1   = absdd * item_i.m2;
  assign mp2   = absdd * item_i.m1;

  always_ff @(posedge clk_i) begin
    num1_q         <= dec_pkg::DIV_N'({mp1, 1'b0}) + dec_pkg::DIV_N'(item_i.msum >> 1);
    num2_q         <= dec_pkg::DIV_N'({mp2, 1'b0}) + dec_pkg::DIV_N'(item_i.msum >> 1);
    den1_q         <= dec_pkg::DIV_D'(item_i.msum);
    side0_q.hit    <= item_i.hit;
    side0_q.bypass <= item_i.bypass;
    side0_q.s1     <= item_i.dd[dec_pkg::DD_W-1];
    side0_q.s2     <= !item_i.dd[dec_pkg::DD_W-1];
    side0_q.nn     <= item_i.nn;
    side0_q.dx     <= item_i.dx;
    side0_q.dy     <= item_i.dy;
    side0_q.v      <= {item_i.v1x, item_i.v1y, item_i.v2x, item_i.v2y};
  end

  dec_div u_div_q1 (.clk_i(clk_i), .num_i(num1_q), .den_i(den1_q), .quo_o(quo1));
  dec_div u_div_q2 (.clk_i(clk_i), .num_i(num2_q), .den_i(den1_q), .quo_o(quo2));

  dec_side_t sd_q [dec_pkg::DIV_Q];
  logic      sv_q [dec_pkg::DIV_Q];

  always_ff @(posedge clk_i) begin
    sd_q[0] <= side0_q;
    for (int i = 1; i < dec_pkg::DIV_Q; i++) begin
      sd_q[i] <= sd_q[i-1];
    end
  end

  // stage b1: projection products
  logic signed [QS_W-1:0] q1s, q2s;
  logic signed [P_W-1:0]  pr_q [4];
  dec_side_t              b1_side_q;
  logic                   b1_valid_q;

  assign q1s = sd_q[dec_pkg::DIV_Q-1].s1 ? -QS_W'(quo1) : QS_W'(quo1);
  assign q2s = sd_q[dec_pkg::DIV_Q-1].s2 ? -QS_W'(quo2) : QS_W'(quo2);

  always_ff @(posedge clk_i) begin
    pr_q[0]   <= q1s * sd_q[dec_pkg::DIV_Q-1].dx;
    pr_q[1]   <= q1s * sd_q[dec_pkg::DIV_Q-1].dy;
    pr_q[2]   <= q2s * sd_q[dec_pkg::DIV_Q-1].dx;
    pr_q[3]   <= q2s * sd_q[dec_pkg::DIV_Q-1].dy;
    b1_side_q <= sd_q[dec_pkg::DIV_Q-1];
  end

  // stage b2: rounded numerators over the squared distance
  logic [dec_pkg::DIV_N-1:0] n2_q [4];
  logic [dec_pkg::DIV_D-1:0] den2_q;
  dec_tail_t                 tail2_q;
  logic                      b2_valid_q;
  logic [dec_pkg::DIV_Q-1:0] quo_d [4];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) begin
      n2_q[i] <= dec_pkg::DIV_N'(pr_q[i][P_W-1] ? -pr_q[i] : pr_q[i])
               + dec_pkg::DIV_N'(b1_side_q.nn >> 1);
      tail2_q.sg[i] <= pr_q[i][P_W-1];
    end
    den2_q         <= dec_pkg::DIV_D'(b1_side_q.nn);
    tail2_q.hit    <= b1_side_q.hit;
    tail2_q.bypass <= b1_side_q.bypass;
    tail2_q.v      <= b1_side_q.v;
  end

  for (genvar g = 0; g < 4; g++) begin : g_div
    dec_div u_div (.clk_i(clk_i), .num_i(n2_q[g]), .den_i(den2_q), .quo_o(quo_d[g]));
  end

  dec_tail_t td_q [dec_pkg::DIV_Q];
  logic      tv_q [dec_pkg::DIV_Q];

  always_ff @(posedge clk_i) begin
    td_q[0] <= tail2_q;
    for (int i = 1; i < dec_pkg::DIV_Q; i++) begin
      td_q[i] <= td_q[i-1];
    end
  end

  // stage b3: add, saturate, present
  dec_tail_t                           tl;
  logic signed [dec_pkg::DELTA_W-1:0]  delta [4];
  logic signed [dec_pkg::VEL_BITS-1:0] vin [4];
  logic signed [dec_pkg::VEL_BITS-1:0] vout [4];
  logic                                done_q, contact_q;
  logic signed [dec_pkg::VEL_BITS-1:0] res_q [4];

  assign tl = td_q[dec_pkg::DIV_Q-1];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      vin[i]   = tl.v[(3-i)*dec_pkg::VEL_BITS +: dec_pkg::VEL_BITS];
      delta[i] = tl.sg[i] ? -dec_pkg::DELTA_W'(quo_d[i][dec_pkg::DELTA_W-2:0])
                          : dec_pkg::DELTA_W'(quo_d[i][dec_pkg::DELTA_W-2:0]);
      vout[i]  = tl.bypass ? vin[i]
               : dec_pkg::sat_vel(dec_pkg::SUM_W'(vin[i]) + dec_pkg::SUM_W'(delta[i]));
    end
  end

  always_ff @(posedge clk_i) begin
    contact_q <= tl.hit;
    res_q     <= vout;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_valid_q <= 1'b0;
      b1_valid_q <= 1'b0;
      b2_valid_q <= 1'b0;
      done_q     <= 1'b0;
      for (int i = 0; i < dec_pkg::DIV_Q; i++) begin
        sv_q[i] <= 1'b0;
        tv_q[i] <= 1'b0;
      end
    end else begin
      b0_valid_q <= valid_i;
      sv_q[0]    <= b0_valid_q;
      tv_q[0]    <= b2_valid_q;
      for (int i = 1; i < dec_pkg::DIV_Q; i++) begin
        sv_q[i] <= sv_q[i-1];
        tv_q[i] <= tv_q[i-1];
      end
      b1_valid_q <= sv_q[dec_pkg::DIV_Q-1];
      b2_valid_q <= b1_valid_q;
      done_q     <= tv_q[dec_pkg::DIV_Q-1];
    end
  end

  assign done_o             = done_q;
  assign contact_o          = contact_q;
  assign new_first_vel_x_o  = res_q[0];
  assign new_first_vel_y_o  = res_q[1];
  assign new_second_vel_x_o = res_q[2];
  assign new_second_vel_y_o = res_q[3];

`ifndef SYNTHESIS
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(b0_valid_q, 67))
    else $error("result without matching request");
  a_divisor : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b0_valid_q && !side0_q.bypass) |-> (side0_q.nn != '0 && den1_q != '0))
    else $error("response scheduled with zero divisor");
`endif

endmodule
`default_nettype wire

### rtl/disk_elastic_collision_unit.sv
// top level of the two-disk elastic collision unit
//
// usage:
//   a request (two disks: positions, velocities, masses, radii) is taken at
//   a rising edge with start_i high and busy_o low. one result per request
//   (contact flag and the four new velocities) appears on the result ports
//   for exactly one cycle with done_o high, in request order.
//   a new request may be given every cycle while busy_o is low. the delay
//   through the unit is set by two 32-stage pipelined dividers in series
//   in the back end (impulse over total mass, projection over squared
//   distance), plus two front stages, the queue and four back stages.
//   the front end classifies each request (far apart, contact, degenerate)
//   and feeds a two-entry queue that the back end drains every cycle, so
//   busy_o stays low in normal use.
//   reset clears all valid bits and the queue; no result follows reset
//   until a new request. the receiver cannot stall: results are shown once.
`timescale 1ns / 1ps
`default_nettype none
module disk_elastic_collision_unit (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  output logic                                     busy_o,
  input  wire logic signed [dec_pkg::POS_BITS-1:0] first_pos_x_i,
  input  wire logic signed [dec_pkg::POS_BITS-1:0] first_pos_y_i,
  input  wire logic signed [dec_pkg::POS_BITS-1:0] second_pos_x_i,
  input  wire logic signed [dec_pkg::POS_BITS-1:0] second_pos_y_i,
  input  wire logic signed [dec_pkg::VEL_BITS-1:0] first_vel_x_i,
  input  wire logic signed [dec_pkg::VEL_BITS-1:0] first_vel_y_i,
  input  wire logic signed [dec_pkg::VEL_BITS-1:0] second_vel_x_i,
  input  wire logic signed [dec_pkg::VEL_BITS-1:0] second_vel_y_i,
  input  wire logic [dec_pkg::MASS_BITS-1:0]       first_mass_i,
  input  wire logic [dec_pkg::MASS_BITS-1:0]       second_mass_i,
  input  wire logic [dec_pkg::RAD_BITS-1:0]        first_radius_i,
  input  wire logic [dec_pkg::RAD_BITS-1:0]        second_radius_i,
  output logic                                     done_o,
  output logic                                     contact_o,
  output logic signed [dec_pkg::VEL_BITS-1:0]      new_first_vel_x_o,
  output logic signed [dec_pkg::VEL_BITS-1:0]      new_first_vel_y_o,
  output logic signed [dec_pkg::VEL_BITS-1:0]      new_second_vel_x_o,
  output logic signed [dec_pkg::VEL_BITS-1:0]      new_second_vel_y_o
);

  logic               accept;
  logic               push;
  logic               full;
  logic               q_valid;
  dec_pkg::dec_item_t f_item;
  dec_pkg::dec_item_t q_item;

  assign accept = start_i && !full;
  assign busy_o = full;

  dec_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .first_pos_x_i  (first_pos_x_i),
    .first_pos_y_i  (first_pos_y_i),
    .second_pos_x_i (second_pos_x_i),
    .second_pos_y_i (second_pos_y_i),
    .first_vel_x_i  (first_vel_x_i),
    .first_vel_y_i  (first_vel_y_i),
    .second_vel_x_i (second_vel_x_i),
    .second_vel_y_i (second_vel_y_i),
    .first_mass_i   (first_mass_i),
    .second_mass_i  (second_mass_i),
    .first_radius_i (first_radius_i),
    .second_radius_i(second_radius_i),
    .push_o         (push),
    .item_o         (f_item)
  );

  dec_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (f_item),
    .full_o (full),
    .valid_o(q_valid),
    .item_o (q_item)
  );

  dec_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .valid_i           (q_valid),
    .item_i            (q_item),
    .done_o            (done_o),
    .contact_o         (contact_o),
    .new_first_vel_x_o (new_first_vel_x_o),
    .new_first_vel_y_o (new_first_vel_y_o),
    .new_second_vel_x_o(new_second_vel_x_o),
    .new_second_vel_y_o(new_second_vel_y_o)
  );

endmodule
`default_nettype wire
